FILE: hw/rtl/swps_pkg.sv
// shared constants and types of the wildcard byte pattern scanner
package swps_pkg;

	// default window depth and the hard limit on pattern length
	localparam int PatternBytesDef = 8;
	localparam int MaxPatternLen = 8;

	// entries in the queue between scan front and result back (power of two)
	localparam int QueueDepth = 2;

	// configuration port
	localparam int CfgIndexW = 3;
	localparam int CfgDataW = 64;

	typedef enum logic [CfgIndexW-1:0] {
		RegRegionStart  = 3'd0,
		RegResultOffset = 3'd1,
		RegPatternBytes = 3'd2,
		RegWildcardMask = 3'd3,
		RegPatternLen   = 3'd4
	} cfg_reg_t;

	// pattern settings seen by the scan front
	typedef struct packed {
		logic [63:0] pattern_bytes;
		logic [7:0]  wildcard_mask;
		logic [3:0]  pattern_length;
	} pattern_cfg_t;

	// address settings seen by the result back
	typedef struct packed {
		logic [63:0] region_start;
		logic [15:0] result_offset;
	} address_cfg_t;

	// one finished region as handed from front to back
	typedef struct packed {
		logic        found;
		logic [31:0] position;
	} scan_rec_t;

endpackage

FILE: hw/rtl/swps_if.sv
// stream interfaces of the scanner: region bytes in, scan results out

interface swps_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface swps_result_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [63:0] match_address;

	modport source (output valid, output found, output match_address, input ready);
	modport sink (input valid, input found, input match_address, output ready);
endinterface

FILE: hw/rtl/wildcard_byte_pattern_scanner.sv
// top level of the wildcard byte pattern scanner
// Takes one region byte per cycle with no gaps, as long as the two-entry result
// queue has room. Each byte shifts into a window of min(8, PATTERN_BYTES)
// bytes and is compared against the pattern in the same cycle, wildcard bytes
// matching anything; the first match of a region is kept. When the byte marked
// last is transferred, a record goes into the queue. If the output register is
// free or being emptied, the next clock edge loads it, and from then on the result
// (found flag and region_start + position + result_offset, or 0) is offered. The
// queue lets the scan run on while a result waits for the sink. Configuration is
// written through wr_en, wr_index and wr_data; the user must write it only while
// no region is in flight, which the block itself does not enforce.
module wildcard_byte_pattern_scanner #(
	parameter int PATTERN_BYTES = swps_pkg::PatternBytesDef
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [swps_pkg::CfgIndexW-1:0]  wr_index,
	input  logic [swps_pkg::CfgDataW-1:0]   wr_data,
	swps_byte_if.sink                       byte_in,
	swps_result_if.source                   result_out
);
	import swps_pkg::*;

	localparam int RecW = $bits(scan_rec_t);

	logic [63:0] region_start_q;
	logic [15:0] result_offset_q;
	logic [63:0] pattern_bytes_q;
	logic [7:0]  wildcard_mask_q;
	logic [3:0]  pattern_length_q;

	pattern_cfg_t pat_cfg;
	address_cfg_t addr_cfg;
	logic         push;
	scan_rec_t    push_rec;
	logic         push_ready;
	logic         pop;
	logic         rec_valid;
	logic [RecW-1:0] pop_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= '0;
			result_offset_q <= '0;
			pattern_bytes_q <= '0;
			wildcard_mask_q <= '0;
			pattern_length_q <= '0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				RegRegionStart: region_start_q <= wr_data[63:0];
				RegResultOffset: result_offset_q <= wr_data[15:0];
				RegPatternBytes: pattern_bytes_q <= wr_data[63:0];
				RegWildcardMask: wildcard_mask_q <= wr_data[7:0];
				RegPatternLen: pattern_length_q <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	assign pat_cfg.pattern_bytes = pattern_bytes_q;
	assign pat_cfg.wildcard_mask = wildcard_mask_q;
	assign pat_cfg.pattern_length = pattern_length_q;
	assign addr_cfg.region_start = region_start_q;
	assign addr_cfg.result_offset = result_offset_q;

	swps_front #(
		.PATTERN_BYTES(PATTERN_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.byte_in(byte_in),
		.cfg(pat_cfg),
		.push(push),
		.push_rec(push_rec),
		.push_ready(push_ready)
	);

	swps_queue #(
		.Width(RecW),
		.Depth(QueueDepth)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_rec),
		.push_ready(push_ready),
		.pop(pop),
		.pop_data(pop_data),
		.pop_valid(rec_valid)
	);

	swps_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(addr_cfg),
		.rec_valid(rec_valid),
		.rec(scan_rec_t'(pop_data)),
		.pop(pop),
		.result_out(result_out)
	);

endmodule

FILE: hw/rtl/swps_queue.sv
// small first-in first-out queue between the scan front and the result back
module swps_queue #(
	parameter int Width = 33,
	parameter int Depth = swps_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] push_data,
	output logic             push_ready,
	input  logic             pop,
	output logic [Width-1:0] pop_data,
	output logic             pop_valid
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign push_ready = (count_q != CntW'(Depth));
	assign pop_valid = (count_q != '0);
	assign pop_data = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push && push_ready)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop && pop_valid)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push && push_ready, pop && pop_valid})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push && push_ready)
			mem_q[wr_ptr_q] <= push_data;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue fill count beyond depth");

	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && pop_valid && !push) |=> push_ready)
		else $error("queue still full after a pop");

	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_ready) |=> pop_valid)
		else $error("queue empty after a push");

endmodule

FILE: hw/rtl/swps_front.sv
// scan front: takes region bytes, keeps the byte window and finds the first match
module swps_front #(
	parameter int PATTERN_BYTES = swps_pkg::PatternBytesDef
) (
	input  logic                    clk,
	input  logic                    arst_n,
	swps_byte_if.sink               byte_in,
	input  swps_pkg::pattern_cfg_t  cfg,
	output logic                    push,
	output swps_pkg::scan_rec_t     push_rec,
	input  logic                    push_ready
);
	import swps_pkg::*;

	localparam int WinLen = (PATTERN_BYTES < MaxPatternLen) ? PATTERN_BYTES : MaxPatternLen;
	localparam logic [3:0] WinLenL = 4'(WinLen);

	logic [7:0]  win_q [WinLen];
	logic [7:0]  win_nx [WinLen];
	logic [31:0] bytes_seen_q;
	logic        match_seen_q;
	logic [31:0] match_position_q;

	logic        accept;
	logic [3:0]  len;
	logic [31:0] seen_nx;
	logic        sel_hit;
	logic        new_hit;
	logic        found_nx;
	logic [31:0] pos_nx;

	assign byte_in.ready = push_ready;
	assign accept = byte_in.valid && push_ready;

	// clamp the length to what the window holds
	assign len = (cfg.pattern_length > WinLenL) ? WinLenL : cfg.pattern_length;

	// window after the incoming byte, newest at entry 0
	always_comb begin
		win_nx[0] = byte_in.data_byte;
		for (int j = 1; j < WinLen; j++)
			win_nx[j] = win_q[j-1];
	end

	// masked compare for every length, then pick the configured one
	always_comb begin
		logic hl;
		sel_hit = 1'b0;
		for (int l = 1; l <= WinLen; l++) begin
			hl = 1'b1;
			for (int k = 0; k < l; k++) begin
				if (!cfg.wildcard_mask[k] && (win_nx[l-1-k] != cfg.pattern_bytes[8*k +: 8]))
					hl = 1'b0;
			end
			if (len == 4'(l))
				sel_hit = hl;
		end
	end

	// saturating byte count and first match position
	assign seen_nx = (bytes_seen_q == '1) ? bytes_seen_q : bytes_seen_q + 32'd1;
	assign new_hit = !match_seen_q && (len != '0) && (seen_nx >= {28'd0, len}) && sel_hit;
	assign found_nx = match_seen_q || new_hit;
	assign pos_nx = new_hit ? (seen_nx - {28'd0, len}) : match_position_q;

	assign push = accept && byte_in.last_byte;
	assign push_rec.found = found_nx;
	assign push_rec.position = pos_nx;

	// region state, cleared once the last byte is transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			match_seen_q <= 1'b0;
			match_position_q <= '0;
		end else if (accept) begin
			if (byte_in.last_byte) begin
				bytes_seen_q <= '0;
				match_seen_q <= 1'b0;
				match_position_q <= '0;
			end else begin
				bytes_seen_q <= seen_nx;
				match_seen_q <= found_nx;
				match_position_q <= pos_nx;
			end
		end
	end

	// byte window; entries older than the region are never compared
	always_ff @(posedge clk) begin
		if (accept)
			win_q <= win_nx;
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (bytes_seen_q == '0) && !match_seen_q)
		else $error("region state not cleared after last byte");

	a_match_only_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(match_seen_q) |-> $past(push))
		else $error("match flag dropped inside a region");

	a_position_held: assert property (@(posedge clk) disable iff (!arst_n)
		(match_seen_q && !push) |=> $stable(match_position_q))
		else $error("first match position overwritten");

endmodule

FILE: hw/rtl/swps_back.sv
// result back: turns a finished region into an address and holds it for the sink
module swps_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  swps_pkg::address_cfg_t  cfg,
	input  logic                    rec_valid,
	input  swps_pkg::scan_rec_t     rec,
	output logic                    pop,
	swps_result_if.source           result_out
);
	import swps_pkg::*;

	logic [63:0] base_q;
	logic        valid_q;
	logic        found_q;
	logic [63:0] address_q;

	// take a record when the output register is free or being emptied
	assign pop = rec_valid && (!valid_q || result_out.ready);

	assign result_out.valid = valid_q;
	assign result_out.found = found_q;
	assign result_out.match_address = address_q;

	// start plus offset, registered from the configuration registers
	always_ff @(posedge clk) begin
		base_q <= cfg.region_start + {48'd0, cfg.result_offset};
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (result_out.ready)
			valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (pop) begin
			found_q <= rec.found;
			address_q <= rec.found ? (base_q + {32'd0, rec.position}) : '0;
		end
	end

	a_zero_when_missing: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !found_q) |-> (address_q == '0))
		else $error("address not zero without a match");

	a_pop_loads: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> valid_q)
		else $error("taken record did not reach the output register");

	a_no_pop_while_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !result_out.ready) |-> !pop)
		else $error("record taken over a held result");

endmodule

FILE: sim/tb_wildcard_byte_pattern_scanner.sv
// testbench of the wildcard byte pattern scanner: directed and random regions against a predictor
module tb_wildcard_byte_pattern_scanner;
	import swps_pkg::*;

	localparam int WindowBytes = PatternBytesDef;
	localparam int LenLimit = (WindowBytes < MaxPatternLen) ? WindowBytes : MaxPatternLen;
	localparam int RandomItems = 1850;
	localparam int WatchdogLimit = 2000;
	localparam int SettleCycles = 4;
	localparam int LongHoldCycles = 200;
	localparam int PressureRegions = 16;

	typedef struct packed {
		logic        found;
		logic [63:0] match_address;
	} scan_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [CfgIndexW-1:0] wr_index;
	logic [CfgDataW-1:0]  wr_data;

	swps_byte_if   byte_bus ();
	swps_result_if result_bus ();

	wildcard_byte_pattern_scanner #(
		.PATTERN_BYTES(WindowBytes)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.byte_in   (byte_bus),
		.result_out(result_bus)
	);

	// register copies held by the predictor
	logic [63:0] cfg_start;
	logic [15:0] cfg_offset;
	logic [63:0] cfg_pattern;
	logic [7:0]  cfg_mask;
	logic [3:0]  cfg_len;

	// scan state of the predictor
	logic [7:0]  win_bytes [WindowBytes];
	logic [31:0] win_count;
	logic        win_hit;
	logic [31:0] win_hit_pos;

	scan_result_t expected_results [$];
	logic [7:0]   region_buf [$];

	int errors = 0;
	int sent_count = 0;
	int idle_cycles = 0;
	int idle_rate = 0;
	int rx_rate = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// clear the predictor scan state
	function automatic void clear_scan_model();
		int k;
		for (k = 0; k < WindowBytes; k++) win_bytes[k] = 8'h00;
		win_count = '0;
		win_hit = 1'b0;
		win_hit_pos = '0;
	endfunction

	// shift one byte into the predictor window and record the first match
	function automatic void scan_model_byte(input logic [7:0] data, input logic last);
		int len;
		int k;
		bit hit;
		scan_result_t res;
		len = (int'(cfg_len) > LenLimit) ? LenLimit : int'(cfg_len);
		for (k = WindowBytes - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
		win_bytes[0] = data;
		if (win_count != 32'hFFFF_FFFF) win_count++;
		if (!win_hit && len > 0 && win_count >= 32'(len)) begin
			hit = 1'b1;
			for (k = 0; k < len; k++) begin
				if (!cfg_mask[k] && win_bytes[len-1-k] != cfg_pattern[8*k +: 8]) hit = 1'b0;
			end
			if (hit) begin
				win_hit = 1'b1;
				win_hit_pos = win_count - 32'(len);
			end
		end
		if (last) begin
			res.found = win_hit;
			res.match_address = win_hit
				? cfg_start + 64'(win_hit_pos) + 64'(cfg_offset)
				: 64'h0;
			expected_results.push_back(res);
			clear_scan_model();
		end
	endfunction

	// one register write, left enabled for a following write
	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		wr_en = 1'b1;
		wr_index = idx;
		wr_data = val;
		@(negedge clk);
		case (idx)
			RegRegionStart:  cfg_start = val;
			RegResultOffset: cfg_offset = val[15:0];
			RegPatternBytes: cfg_pattern = val;
			RegWildcardMask: cfg_mask = val[7:0];
			RegPatternLen:   cfg_len = val[3:0];
			default: ;
		endcase
	endtask

	// stop sending and wait until every result is in and the block has settled
	task automatic wait_idle();
		byte_bus.valid = 1'b0;
		while (expected_results.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	// write all registers once the block is idle
	task automatic apply_pattern(input logic [63:0] start, input logic [15:0] offset,
			input logic [63:0] pat, input logic [7:0] mask, input logic [3:0] len);
		wait_idle();
		write_reg(RegRegionStart, start);
		write_reg(RegResultOffset, 64'(offset));
		write_reg(RegPatternBytes, pat);
		write_reg(RegWildcardMask, 64'(mask));
		write_reg(RegPatternLen, 64'(len));
		wr_en = 1'b0;
	endtask

	// offer one byte, with a random gap in front, until it is transferred
	task automatic send_byte(input logic [7:0] data, input logic last);
		if (!quiet && idle_rate > 0 && $urandom_range(0, 15) < idle_rate) begin
			byte_bus.valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		byte_bus.valid = 1'b1;
		byte_bus.data_byte = data;
		byte_bus.last_byte = last;
		@(posedge clk);
		while (!byte_bus.ready) @(posedge clk);
		scan_model_byte(data, last);
		sent_count++;
		@(negedge clk);
	endtask

	// send the buffered region, last flag on its final byte
	task automatic send_region();
		int i;
		for (i = 0; i < region_buf.size(); i++) send_byte(region_buf[i], i == region_buf.size() - 1);
	endtask

	// registers at reset: empty pattern, nothing found
	task automatic test_reset_state();
		region_buf = '{8'h00, 8'hFF};
		send_region();
	endtask

	// exact pattern with the address wrapping, second occurrence ignored
	task automatic test_exact_match();
		apply_pattern(64'hFFFF_FFFF_FFFF_FFF0, 16'hFFFF, 64'h0123_4567_DEAD_BEEF, 8'h00, 4'd4);
		region_buf = '{8'h00, 8'hEF, 8'hBE, 8'hAD, 8'hDE, 8'hEF, 8'hBE, 8'hAD, 8'hDE};
		send_region();
	endtask

	// overlong length clamps to the window; match may not run off the region start
	task automatic test_overlong_wildcard();
		apply_pattern(64'h0, 16'h0, 64'h0, 8'hFF, 4'd15);
		region_buf = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
		send_region();
	endtask

	// zero length never matches even with every byte wild
	task automatic test_empty_pattern();
		apply_pattern(64'h1234, 16'h0001, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 4'd0);
		region_buf = '{8'hAA};
		send_region();
	endtask

	// one-byte region matching at position zero, address zero
	task automatic test_single_byte();
		apply_pattern(64'h0, 16'h0, 64'h0, 8'h00, 4'd1);
		region_buf = '{8'h00};
		send_region();
	endtask

	// sink holds off while short regions are offered, then the results drain
	task automatic test_backpressure();
		int r;
		apply_pattern(64'h8000_0000_0000_0000, 16'h00FF, 64'h0, 8'hFF, 4'd1);
		idle_rate = 0;
		rx_rate = 0;
		hold_req = 1'b1;
		for (r = 0; r < PressureRegions; r++) begin
			region_buf.delete();
			region_buf.push_back(8'($urandom()));
			if (r[0]) region_buf.push_back(8'($urandom()));
			send_region();
		end
		wait_idle();
	endtask

	// random settings, regions mostly carrying the pattern, some broken or pure noise
	task automatic test_random_regions();
		int stop_at;
		int quiet_at;
		int sel;
		int nreg;
		int r;
		int k;
		int len_eff;
		int region_len;
		int pos;
		int mode;
		logic [63:0] start;
		logic [15:0] offset;
		logic [63:0] pat;
		logic [7:0]  mask;
		logic [3:0]  len;
		stop_at = sent_count + RandomItems;
		quiet_at = sent_count + RandomItems * 9 / 10;
		while (sent_count < stop_at) begin
			// settings of this phase, extremes among them
			sel = $urandom_range(0, 3);
			start = (sel == 0) ? 64'h0 : (sel == 1) ? 64'hFFFF_FFFF_FFFF_FFFF
				: {$urandom(), $urandom()};
			sel = $urandom_range(0, 3);
			offset = (sel == 0) ? 16'h0 : (sel == 1) ? 16'hFFFF : 16'($urandom());
			sel = $urandom_range(0, 7);
			pat = (sel == 0) ? 64'h0 : (sel == 1) ? 64'hFFFF_FFFF_FFFF_FFFF
				: {$urandom(), $urandom()};
			sel = $urandom_range(0, 3);
			mask = (sel == 1) ? 8'($urandom()) : (sel == 3) ? 8'hFF : 8'h00;
			len = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
				: 4'($urandom_range(0, 8));
			apply_pattern(start, offset, pat, mask, len);
			idle_rate = $urandom_range(0, 4);
			rx_rate = $urandom_range(0, 4);
			len_eff = (int'(cfg_len) > LenLimit) ? LenLimit : int'(cfg_len);
			nreg = $urandom_range(1, 8);
			for (r = 0; r < nreg; r++) begin
				if (sent_count >= quiet_at) quiet = 1'b1;
				mode = $urandom_range(0, 9);
				region_len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 48)
					: $urandom_range(1, 16);
				if (mode < 8 && len_eff > region_len) region_len = len_eff;
				// fill drawn partly from the pattern bytes for chance matches
				region_buf.delete();
				for (k = 0; k < region_len; k++) begin
					sel = $urandom_range(0, 7);
					region_buf.push_back($urandom_range(0, 1) ? cfg_pattern[8*sel +: 8]
						: 8'($urandom()));
				end
				// embed the pattern, one byte spoilt in a broken sequence
				if (mode < 8 && len_eff > 0) begin
					pos = $urandom_range(0, region_len - len_eff);
					for (k = 0; k < len_eff; k++) begin
						if (!cfg_mask[k]) region_buf[pos+k] = cfg_pattern[8*k +: 8];
					end
					if (mode == 7) begin
						k = $urandom_range(0, len_eff - 1);
						region_buf[pos+k] = region_buf[pos+k] ^ (8'h01 << $urandom_range(0, 7));
					end
				end
				send_region();
			end
		end
	endtask

	// result sink: random stalls, one long hold-off on request
	initial begin : result_sink
		int stall_left;
		int hold_left;
		bit hold_taken;
		logic rdy;
		stall_left = 0;
		hold_left = 0;
		hold_taken = 1'b0;
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = LongHoldCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else if (!quiet && rx_rate > 0 && $urandom_range(0, 15) < rx_rate) begin
				stall_left = $urandom_range(1, 18) - 1;
				rdy = 1'b0;
			end else begin
				rdy = 1'b1;
			end
			result_bus.ready = rdy;
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin : result_check
		scan_result_t want;
		if (result_bus.valid && result_bus.ready) begin
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual found=%0b address=%h",
					$time, result_bus.found, result_bus.match_address);
			end else begin
				want = expected_results.pop_front();
				if (result_bus.found !== want.found) begin
					errors++;
					$display("%0t: found mismatch, expected %0b, actual %0b",
						$time, want.found, result_bus.found);
				end
				if (result_bus.match_address !== want.match_address) begin
					errors++;
					$display("%0t: match_address mismatch, expected %h, actual %h",
						$time, want.match_address, result_bus.match_address);
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((byte_bus.valid && byte_bus.ready) || (result_bus.valid && result_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// sequence of tests
	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = RegRegionStart;
		wr_data = '0;
		byte_bus.valid = 1'b0;
		byte_bus.data_byte = 8'h00;
		byte_bus.last_byte = 1'b0;
		cfg_start = '0;
		cfg_offset = '0;
		cfg_pattern = '0;
		cfg_mask = '0;
		cfg_len = '0;
		clear_scan_model();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_exact_match();
		test_overlong_wildcard();
		test_empty_pattern();
		test_single_byte();
		test_backpressure();
		test_random_regions();

		wait_idle();
		repeat (2 * SettleCycles) @(negedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/swps_pkg.sv
hw/rtl/swps_if.sv
hw/rtl/swps_queue.sv
hw/rtl/swps_front.sv
hw/rtl/swps_back.sv
hw/rtl/wildcard_byte_pattern_scanner.sv
sim/tb_wildcard_byte_pattern_scanner.sv
